@@ hw/rtl/magma_pkg.sv @@
// ----------------------------------------------------------------------------
// Magma cipher package
// Shared types, constants, S-box table and round function for the pipeline.
// ----------------------------------------------------------------------------
package magma_pkg;

  localparam int unsigned ROUNDS      = 32;
  localparam int unsigned KEY_COUNT   = 8;
  localparam int unsigned FIRST_SPLIT = 24;
  localparam int unsigned ROT_LEFT    = 11;
  localparam int unsigned ROT_RIGHT   = 21;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned BLOCK_W     = 64;
  localparam int unsigned KEY_IDX_W   = 3;
  localparam int unsigned CFG_IDX_W   = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_PAIR_0 = 3'd0,
    REG_KEY_PAIR_1 = 3'd1,
    REG_KEY_PAIR_2 = 3'd2,
    REG_KEY_PAIR_3 = 3'd3
  } cfg_reg_t;

  typedef logic [HALF_W-1:0] half_t;
  typedef logic [KEY_COUNT-1:0][HALF_W-1:0] key_set_t;

  // One pipeline slot: valid flag, direction and the two halves
  typedef struct packed {
    logic  valid;
    logic  dec;
    half_t a1;
    half_t a0;
  } stage_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // Subkey used in a given round for a given direction
  function automatic logic [KEY_IDX_W-1:0] key_index(input int unsigned rnd,
                                                    input logic dec);
    logic [KEY_IDX_W-1:0] fwd;
    logic [KEY_IDX_W-1:0] rev;
    fwd = KEY_IDX_W'(rnd % KEY_COUNT);
    rev = KEY_IDX_W'(KEY_COUNT - 1 - (rnd % KEY_COUNT));
    if (dec) begin
      return (rnd < KEY_COUNT) ? fwd : rev;
    end
    return (rnd < FIRST_SPLIT) ? fwd : rev;
  endfunction

  // Add key mod 2^32, substitute each nibble, rotate left by ROT_LEFT
  function automatic half_t round_f(input half_t a, input half_t k);
    half_t x;
    half_t y;
    x = a + k;
    for (int i = 0; i < 8; i++) begin
      y[4*i +: 4] = SBOX[i][x[4*i +: 4]];
    end
    return (y << ROT_LEFT) | (y >> ROT_RIGHT);
  endfunction

endpackage

@@ hw/rtl/magma_key_regs.sv @@
// ----------------------------------------------------------------------------
// Magma key registers
// Four 64-bit key pair registers, presented as eight 32-bit subkeys.
// ----------------------------------------------------------------------------
module magma_key_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [magma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [magma_pkg::BLOCK_W-1:0]    cfg_data,
  output magma_pkg::key_set_t              keys
);

  logic [magma_pkg::BLOCK_W-1:0] key_pair [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_pair[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (magma_pkg::cfg_reg_t'(cfg_index))
        magma_pkg::REG_KEY_PAIR_0: key_pair[0] <= cfg_data;
        magma_pkg::REG_KEY_PAIR_1: key_pair[1] <= cfg_data;
        magma_pkg::REG_KEY_PAIR_2: key_pair[2] <= cfg_data;
        magma_pkg::REG_KEY_PAIR_3: key_pair[3] <= cfg_data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Even subkey in the upper half, odd subkey in the lower half
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      keys[2*i]   = key_pair[i][magma_pkg::BLOCK_W-1:magma_pkg::HALF_W];
      keys[2*i+1] = key_pair[i][magma_pkg::HALF_W-1:0];
    end
  end

endmodule

@@ hw/rtl/magma_round.sv @@
// ----------------------------------------------------------------------------
// Magma round stage
// One registered Feistel round; the last round leaves the halves unswapped.
// ----------------------------------------------------------------------------
module magma_round #(
  parameter int unsigned ROUND = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  magma_pkg::key_set_t keys,
  input  magma_pkg::stage_t   stage_in,
  output magma_pkg::stage_t   stage_out
);

  localparam logic [magma_pkg::KEY_IDX_W-1:0] KIDX_ENC = magma_pkg::key_index(ROUND, 1'b0);
  localparam logic [magma_pkg::KEY_IDX_W-1:0] KIDX_DEC = magma_pkg::key_index(ROUND, 1'b1);
  localparam bit LAST = (ROUND == magma_pkg::ROUNDS - 1);

  magma_pkg::half_t  k;
  magma_pkg::half_t  t;
  magma_pkg::stage_t stage_next;

  always_comb begin
    k     = stage_in.dec ? keys[KIDX_DEC] : keys[KIDX_ENC];
    t     = magma_pkg::round_f(stage_in.a0, k) ^ stage_in.a1;
    stage_next       = stage_in;
    if (LAST) begin
      stage_next.a1 = t;
    end else begin
      stage_next.a1 = stage_in.a0;
      stage_next.a0 = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.dec <= stage_next.dec;
    stage_out.a1  <= stage_next.a1;
    stage_out.a0  <= stage_next.a0;
  end

endmodule

@@ hw/rtl/magma_block_cipher_ecb.sv @@
// ----------------------------------------------------------------------------
// Magma block cipher, ECB
// Fully unrolled 64-bit Magma cipher, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive block_in and decrypt with start high; the block is
//   taken at any rising edge where start is high and busy is low. busy is
//   high only during reset, so a new block can be transferred every cycle.
//   Result channel: result_valid strobes for exactly one cycle with
//   block_out, after the block has passed the 32 round stages. The receiver
//   has no way to hold results off and must take each one as it appears.
//   Throughput is one block per cycle through the 32 round stages, each
//   holding one add, one S-box layer and one XOR.
//   Key port: cfg_valid with cfg_index (0..3 = key_pair_0..3) and cfg_data
//   writes a 64-bit key pair; cfg_ready is always high. Indexes 4 and up are
//   dropped. Change keys only while no blocks are in flight.
//   Reset (rst, synchronous) clears all keys to zero and empties the
//   pipeline; blocks in flight are lost and no result follows them.
// ----------------------------------------------------------------------------
module magma_block_cipher_ecb (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [magma_pkg::BLOCK_W-1:0]       block_in,
  input  logic                                decrypt,
  // result channel
  output logic                                result_valid,
  output logic [magma_pkg::BLOCK_W-1:0]       block_out,
  // key write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [magma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [magma_pkg::BLOCK_W-1:0]       cfg_data
);

  magma_pkg::key_set_t keys;
  magma_pkg::stage_t   pipe [magma_pkg::ROUNDS+1];

  // Hold off commands only while reset is applied
  assign busy      = rst;
  assign cfg_ready = 1'b1;

  magma_key_regs u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  // Entry slot: split the block into left (a1) and right (a0) halves
  always_comb begin
    pipe[0].valid = start & ~busy;
    pipe[0].dec   = decrypt;
    pipe[0].a1    = block_in[magma_pkg::BLOCK_W-1:magma_pkg::HALF_W];
    pipe[0].a0    = block_in[magma_pkg::HALF_W-1:0];
  end

  // Advance one round per stage; the valid bit travels with the halves
  for (genvar r = 0; r < magma_pkg::ROUNDS; r++) begin : g_round
    magma_round #(
      .ROUND (r)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .keys      (keys),
      .stage_in  (pipe[r]),
      .stage_out (pipe[r+1])
    );
  end

  // The last stage register is the output register
  assign result_valid = pipe[magma_pkg::ROUNDS].valid;
  assign block_out    = {pipe[magma_pkg::ROUNDS].a1, pipe[magma_pkg::ROUNDS].a0};

endmodule

@@ hw/rtl/magma_checker.sv @@
// ----------------------------------------------------------------------------
// Magma port checker
// Checks on the command, result and key channels, bound to the top level.
// ----------------------------------------------------------------------------
module magma_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            result_valid,
  input logic [magma_pkg::BLOCK_W-1:0]   block_out,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  logic accept;
  assign accept = start & ~busy;

  // Every transfer yields a result exactly after the pipeline latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##32 result_valid)
    else $error("no result 32 cycles after a command transfer");

  // No result appears without a matching transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, 32))
    else $error("result without a command transfer");

  // Reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result straight after reset");

  // Key port and command port never stall out of reset
  a_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> (cfg_ready && !busy))
    else $error("stall outside reset");

  // A result never carries unknown bits
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !$isunknown(block_out))
    else $error("unknown bits on block_out");

endmodule

bind magma_block_cipher_ecb magma_checker u_magma_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .block_out    (block_out),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Magma ECB cipher testbench
// Streams 64-bit blocks through the unrolled cipher in both directions under
// several key settings. A table of directed blocks comes first, including the
// published GOST R 34.12-2015 known-answer pair. Long random runs follow, with
// the sender pausing at random. An in-bench model of the cipher predicts each
// output block but for the known-answer rows, which use their typed-in
// answers; every result strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROUNDS      = magma_pkg::ROUNDS;
  localparam int unsigned KEY_COUNT   = magma_pkg::KEY_COUNT;
  localparam int unsigned FIRST_SPLIT = magma_pkg::FIRST_SPLIT;
  localparam int unsigned ROT_LEFT    = magma_pkg::ROT_LEFT;
  localparam int unsigned HALF_W      = magma_pkg::HALF_W;
  localparam int unsigned BLOCK_W     = magma_pkg::BLOCK_W;
  localparam int unsigned KEY_IDX_W   = magma_pkg::KEY_IDX_W;
  localparam int unsigned CFG_IDX_W   = magma_pkg::CFG_IDX_W;

  localparam int unsigned NUM_KEY_REGS   = 4;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned IDLE_PERCENT   = 27;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS    = 238;
  localparam int unsigned STEADY_PHASE   = 2;   // sender never pauses here
  localparam int unsigned PAUSE_PHASE    = 3;   // sender waits for an empty pipe
  localparam int unsigned TAIL_CYCLES    = 2 * ROUNDS + 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned N_VECTORS      = 20;

  localparam logic ENCRYPT = 1'b0;
  localparam logic DECRYPT = 1'b1;

  localparam logic [BLOCK_W-1:0] ALL_ONES = {BLOCK_W{1'b1}};

  // Standard S-boxes: row n substitutes nibble n, counted from the LSB
  localparam logic [3:0] SUBST [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // Key settings used by the directed table
  typedef enum logic [1:0] {
    KEYS_ZERO,
    KEYS_STANDARD,
    KEYS_ONES
  } key_choice_t;

  localparam logic [BLOCK_W-1:0] KEY_TABLE [3][NUM_KEY_REGS] = '{
    '{64'h0, 64'h0, 64'h0, 64'h0},
    '{64'hFFEE_DDCC_BBAA_9988, 64'h7766_5544_3322_1100,
      64'hF0F1_F2F3_F4F5_F6F7, 64'hF8F9_FAFB_FCFD_FEFF},
    '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}
  };

  // One directed block; known_out is used only where known is set
  typedef struct packed {
    key_choice_t        keys;
    logic [BLOCK_W-1:0] blk;
    logic               dir;
    logic               known;
    logic [BLOCK_W-1:0] known_out;
  } vector_t;

  vector_t vectors [N_VECTORS] = '{
    // all-zero key straight out of reset: extremes and half patterns
    '{KEYS_ZERO,     64'h0000_0000_0000_0000, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_ZERO,     64'h0000_0000_0000_0000, DECRYPT, 1'b0, 64'h0},
    '{KEYS_ZERO,     64'hFFFF_FFFF_FFFF_FFFF, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_ZERO,     64'hFFFF_FFFF_FFFF_FFFF, DECRYPT, 1'b0, 64'h0},
    '{KEYS_ZERO,     64'h8000_0000_0000_0000, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_ZERO,     64'h0000_0000_0000_0001, DECRYPT, 1'b0, 64'h0},
    '{KEYS_ZERO,     64'hFFFF_FFFF_0000_0000, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_ZERO,     64'h0000_0000_FFFF_FFFF, DECRYPT, 1'b0, 64'h0},
    // published known-answer pair, both directions
    '{KEYS_STANDARD, 64'hFEDC_BA98_7654_3210, ENCRYPT, 1'b1, 64'h4EE9_01E5_C2D8_CA3D},
    '{KEYS_STANDARD, 64'h4EE9_01E5_C2D8_CA3D, DECRYPT, 1'b1, 64'hFEDC_BA98_7654_3210},
    '{KEYS_STANDARD, 64'h0000_0000_0000_0000, DECRYPT, 1'b0, 64'h0},
    '{KEYS_STANDARD, 64'hFFFF_FFFF_FFFF_FFFF, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_STANDARD, 64'h0123_4567_89AB_CDEF, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_STANDARD, 64'hAAAA_AAAA_AAAA_AAAA, DECRYPT, 1'b0, 64'h0},
    // all-ones key: every modular addition with a nonzero half carries
    '{KEYS_ONES,     64'h0000_0000_0000_0000, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_ONES,     64'h0000_0000_0000_0000, DECRYPT, 1'b0, 64'h0},
    '{KEYS_ONES,     64'hFFFF_FFFF_FFFF_FFFF, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_ONES,     64'hFFFF_FFFF_FFFF_FFFF, DECRYPT, 1'b0, 64'h0},
    '{KEYS_ONES,     64'h5555_5555_5555_5555, ENCRYPT, 1'b0, 64'h0},
    '{KEYS_ONES,     64'hAAAA_AAAA_AAAA_AAAA, DECRYPT, 1'b0, 64'h0}
  };

  // Clock and DUT inputs, all known from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [BLOCK_W-1:0]   block_in = '0;
  logic                 decrypt = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BLOCK_W-1:0]   cfg_data = '0;

  logic                 busy;
  logic                 result_valid;
  logic [BLOCK_W-1:0]   block_out;
  logic                 cfg_ready;

  // Side-band held alongside start: a typed-in answer for the current block
  logic                 pinned = 1'b0;
  logic [BLOCK_W-1:0]   pinned_out = '0;

  // Bench copy of the key registers and the blocks still owed by the DUT
  logic [BLOCK_W-1:0]   key_copy [NUM_KEY_REGS];
  logic [BLOCK_W-1:0]   owed_blocks [$];
  logic [BLOCK_W-1:0]   owed_head;
  logic [BLOCK_W-1:0]   owed_tail;
  int unsigned          mismatch_count = 0;
  int unsigned          quiet_cycles = 0;
  bit                   steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  magma_block_cipher_ecb u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .block_in     (block_in),
    .decrypt      (decrypt),
    .result_valid (result_valid),
    .block_out    (block_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Cipher model
  // --------------------------------------------------------------------------

  // Round function: add the subkey mod 2^32, substitute, rotate left by 11
  function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] a,
                                                 input logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] sum;
    logic [HALF_W-1:0] sub;
    sum = a + k;
    for (int n = 0; n < 8; n++) begin
      sub[4*n +: 4] = SUBST[n][sum[4*n +: 4]];
    end
    return {sub[HALF_W-ROT_LEFT-1:0], sub[HALF_W-1:HALF_W-ROT_LEFT]};
  endfunction

  // Full 32-round Feistel pass over one block with the current key copy
  function automatic logic [BLOCK_W-1:0] magma_transform(input logic [BLOCK_W-1:0] blk,
                                                         input logic dir);
    logic [HALF_W-1:0]    left;
    logic [HALF_W-1:0]    right;
    logic [HALF_W-1:0]    mixed;
    logic [HALF_W-1:0]    k;
    logic [KEY_IDX_W-1:0] sel;
    left  = blk[BLOCK_W-1:HALF_W];
    right = blk[HALF_W-1:0];
    for (int unsigned r = 0; r < ROUNDS; r++) begin
      // forward order K0..K7 for the first pass (three passes when encrypting),
      // reversed order afterwards
      if (r < ((dir == DECRYPT) ? KEY_COUNT : FIRST_SPLIT)) begin
        sel = KEY_IDX_W'(r % KEY_COUNT);
      end else begin
        sel = KEY_IDX_W'(KEY_COUNT - 1 - (r % KEY_COUNT));
      end
      k = sel[0] ? key_copy[sel[KEY_IDX_W-1:1]][HALF_W-1:0]
                 : key_copy[sel[KEY_IDX_W-1:1]][BLOCK_W-1:HALF_W];
      mixed = mix_half(right, k) ^ left;
      // the last round leaves the halves unswapped
      if (r < ROUNDS - 1) begin
        left  = right;
        right = mixed;
      end else begin
        left = mixed;
      end
    end
    return {left, right};
  endfunction

  // --------------------------------------------------------------------------
  // Random pickers
  // --------------------------------------------------------------------------

  function automatic logic [BLOCK_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ALL_ONES;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [BLOCK_W-1:0] pick_block();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return 64'h1 << $urandom_range(0, BLOCK_W - 1);
      3: return ~(64'h1 << $urandom_range(0, BLOCK_W - 1));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one key write and hold it until transferred. Leave cfg_valid high
  // so that a following write is not dropped and raised in the same step;
  // the caller lowers it after the last write of a batch.
  task automatic put_key(input logic [CFG_IDX_W-1:0] idx, input logic [BLOCK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_keys(input logic [BLOCK_W-1:0] k0, input logic [BLOCK_W-1:0] k1,
                           input logic [BLOCK_W-1:0] k2, input logic [BLOCK_W-1:0] k3);
    put_key(magma_pkg::REG_KEY_PAIR_0, k0);
    put_key(magma_pkg::REG_KEY_PAIR_1, k1);
    put_key(magma_pkg::REG_KEY_PAIR_2, k2);
    put_key(magma_pkg::REG_KEY_PAIR_3, k3);
  endtask

  // Offer one block, idling first at random unless in the steady stretch,
  // and return at the edge that transfers it
  task automatic send_block(input logic [BLOCK_W-1:0] blk, input logic dir,
                            input logic known, input logic [BLOCK_W-1:0] known_out);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    block_in   <= blk;
    decrypt    <= dir;
    pinned     <= known;
    pinned_out <= known_out;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold until every owed block has come out. The first edge
  // lets the monitor log a block transferred in this very step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (owed_blocks.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Monitor and checker: sample at the rising edge, results before new
  // blocks so that a block transferred on the same edge is never matched
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      foreach (key_copy[n]) begin
        key_copy[n] = '0;
      end
    end else begin
      if (result_valid) begin
        if (owed_blocks.size() == 0) begin
          $error("block_out: expected none, actual %h", block_out);
          mismatch_count++;
        end else begin
          owed_head = owed_blocks.pop_front();
          if (block_out !== owed_head) begin
            $error("block_out: expected %h, actual %h", owed_head, block_out);
            mismatch_count++;
          end
        end
      end
      // indexes past the key map are ignored by the block
      if (cfg_valid && cfg_ready && cfg_index < NUM_KEY_REGS) begin
        key_copy[cfg_index[1:0]] = cfg_data;
      end
      if (start && !busy) begin
        owed_tail   = pinned ? pinned_out : magma_transform(block_in, decrypt);
        owed_blocks = {owed_blocks, owed_tail};
      end
      if (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Watchdog: end the run if nothing has been transferred for too long
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    key_choice_t        active_keys;
    logic [BLOCK_W-1:0] rand_keys [NUM_KEY_REGS];
    active_keys = KEYS_ZERO;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table: the first rows run on the reset keys, later rows swap
    // the key set only once the pipeline is empty
    foreach (vectors[v]) begin
      if (vectors[v].keys != active_keys) begin
        drain();
        load_keys(KEY_TABLE[vectors[v].keys][0], KEY_TABLE[vectors[v].keys][1],
                  KEY_TABLE[vectors[v].keys][2], KEY_TABLE[vectors[v].keys][3]);
        // stray writes above the key map must leave the standard key intact,
        // which the known-answer rows then prove
        if (vectors[v].keys == KEYS_STANDARD) begin
          for (int unsigned n = NUM_KEY_REGS; n < 2 ** CFG_IDX_W; n++) begin
            put_key(CFG_IDX_W'(n), ALL_ONES);
          end
        end
        cfg_valid <= 1'b0;
        active_keys = vectors[v].keys;
      end
      send_block(vectors[v].blk, vectors[v].dir, vectors[v].known, vectors[v].known_out);
    end

    // Random phases: fresh keys each time, one stray write past the key map,
    // then a long run of random blocks in both directions
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      foreach (rand_keys[n]) begin
        rand_keys[n] = pick_key();
      end
      load_keys(rand_keys[0], rand_keys[1], rand_keys[2], rand_keys[3]);
      put_key(CFG_IDX_W'($urandom_range(NUM_KEY_REGS, 2 ** CFG_IDX_W - 1)),
              {$urandom(), $urandom()});
      cfg_valid <= 1'b0;
      steady = (p == STEADY_PHASE);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // once, hold the sender until the pipeline has fully emptied
        if (p == PAUSE_PHASE && i == PHASE_ITEMS / 2) begin
          drain();
        end
        send_block(pick_block(), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    // Wait for the last blocks, then a little longer for any stray strobe
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
